@@ sv/terd_pkg.sv @@
// shared types and constants of the terrain record deframer
package terd_pkg;

  // result kinds as they appear on the output tuser
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_ELEV   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  // record status codes
  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BAD_SENTINEL = 2'd1,
    ST_BAD_SUM      = 2'd2
  } status_e;

  localparam int unsigned POS_W     = 13;
  localparam int unsigned PTS_W     = 12;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned HDR_W     = 56;
  localparam int unsigned OUT_DATA_W = 88;

  localparam logic [POS_W-1:0] HDR_BYTES    = 13'd8;
  localparam logic [POS_W-1:0] HDR_LAST_POS = 13'd7;
  localparam logic [POS_W-1:0] SUM_LAST_OFF = 13'd3;
  localparam logic [7:0]       SENTINEL     = 8'hAA;
  localparam logic [PTS_W-1:0] PTS_RESET    = 12'd1201;

  // queue between the front and the back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // one classified result on its way to the back
  // header:    payload = {block, lon, lat}
  // elevation: payload = {zeros, index, raw sign-magnitude pair}
  // status:    payload = {zeros, status}
  typedef struct packed {
    kind_e             kind;
    logic [HDR_W-1:0]  payload;
  } token_t;

endpackage

@@ sv/terd_front.sv @@
// front end: takes record bytes, tracks the record layout and builds result tokens
module terd_front #(
  parameter int unsigned MaxPoints = 3601
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [terd_pkg::PTS_W-1:0]   points_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   in_byte_i,
  input  logic                         full_i,
  output logic                         push_o,
  output terd_pkg::token_t             token_o
);

  localparam logic [terd_pkg::PTS_W-1:0] MAX_PTS = terd_pkg::PTS_W'(MaxPoints);

  logic [terd_pkg::POS_W-1:0] pos_q, pos_d;
  logic [terd_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [terd_pkg::SUM_W-1:0] rx_q, rx_d;
  logic                       sb_q, sb_d;
  logic [7:0]                 hold_q, hold_d;
  logic [terd_pkg::HDR_W-1:0] hdr_q, hdr_d;

  logic                       accept;
  logic [terd_pkg::PTS_W-1:0] eff_pts;
  logic [terd_pkg::POS_W-1:0] cpos;
  logic [terd_pkg::POS_W-1:0] elev_off;
  logic [terd_pkg::POS_W-1:0] chk_off;
  logic [terd_pkg::SUM_W-1:0] rx_new;
  terd_pkg::status_e          st;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  // clamp the point count and find where the checksum starts
  always_comb begin
    if (points_i == '0) begin
      eff_pts = terd_pkg::PTS_W'(1);
    end else if (points_i > MAX_PTS) begin
      eff_pts = MAX_PTS;
    end else begin
      eff_pts = points_i;
    end
  end

  assign cpos     = terd_pkg::HDR_BYTES + {eff_pts, 1'b0};
  assign elev_off = pos_q - terd_pkg::HDR_BYTES;
  assign chk_off  = pos_q - cpos;
  assign rx_new   = {rx_q[terd_pkg::SUM_W-9:0], in_byte_i};

  // record verdict, a bad sentinel ahead of a checksum mismatch
  always_comb begin
    if (sb_q) begin
      st = terd_pkg::ST_BAD_SENTINEL;
    end else if (rx_new != sum_q) begin
      st = terd_pkg::ST_BAD_SUM;
    end else begin
      st = terd_pkg::ST_OK;
    end
  end

  // byte classification and state update
  always_comb begin
    pos_d   = pos_q;
    sum_d   = sum_q;
    rx_d    = rx_q;
    sb_d    = sb_q;
    hold_d  = hold_q;
    hdr_d   = hdr_q;
    push_o  = 1'b0;
    token_o.kind    = terd_pkg::KIND_HEADER;
    token_o.payload = '0;
    if (accept) begin
      if (pos_q < cpos) begin
        sum_d = sum_q + terd_pkg::SUM_W'(in_byte_i);
        if (pos_q == '0) begin
          sb_d  = (in_byte_i != terd_pkg::SENTINEL);
          pos_d = terd_pkg::POS_W'(1);
        end else if (pos_q < terd_pkg::HDR_BYTES) begin
          hdr_d = {hdr_q[terd_pkg::HDR_W-9:0], in_byte_i};
          pos_d = pos_q + 1'b1;
          if (pos_q == terd_pkg::HDR_LAST_POS && !sb_q) begin
            push_o          = 1'b1;
            token_o.kind    = terd_pkg::KIND_HEADER;
            token_o.payload = hdr_d;
          end
        end else begin
          pos_d = pos_q + 1'b1;
          if (!elev_off[0]) begin
            hold_d = in_byte_i;
          end else if (!sb_q) begin
            push_o          = 1'b1;
            token_o.kind    = terd_pkg::KIND_ELEV;
            token_o.payload = {28'd0, elev_off[terd_pkg::POS_W-1:1], hold_q, in_byte_i};
          end
        end
      end else begin
        if (chk_off >= terd_pkg::SUM_LAST_OFF) begin
          push_o          = 1'b1;
          token_o.kind    = terd_pkg::KIND_STATUS;
          token_o.payload = {54'd0, st};
          pos_d = '0;
          sum_d = '0;
          rx_d  = '0;
          sb_d  = 1'b0;
        end else begin
          rx_d  = rx_new;
          pos_d = pos_q + 1'b1;
        end
      end
    end
  end

  // control and running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
      rx_q  <= '0;
      sb_q  <= 1'b0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
      rx_q  <= rx_d;
      sb_q  <= sb_d;
    end
  end

  // header and elevation holding registers
  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    hdr_q  <= hdr_d;
  end

  // a status token always closes the record
  a_status_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && token_o.kind == terd_pkg::KIND_STATUS) |=> (pos_q == '0))
    else $error("record position not cleared after status");

endmodule

@@ sv/terd_queue.sv @@
// short token queue between the front and the back
module terd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  terd_pkg::token_t token_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output terd_pkg::token_t token_o
);

  terd_pkg::token_t            mem_q [terd_pkg::QDEPTH];
  logic [terd_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [terd_pkg::QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == terd_pkg::QCNT_W'(terd_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign token_o = mem_q[rd_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= token_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= terd_pkg::QCNT_W'(terd_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("pop from empty queue");

endmodule

@@ sv/terd_back.sv @@
// back end: decodes tokens into result beats and holds them in the output register
module terd_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  terd_pkg::token_t                  q_token_i,
  output logic                              q_pop_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [terd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic [1:0]                        m_axis_tuser,
  output logic                              m_axis_tlast
);

  logic                                valid_q;
  terd_pkg::kind_e                     kind_q;
  logic [terd_pkg::OUT_DATA_W-1:0]     data_q;
  logic                                last_q;

  logic [23:0]                         block_nr;
  logic [15:0]                         lon, lat;
  logic [11:0]                         idx;
  logic [15:0]                         mag;
  logic signed [15:0]                  height;
  logic [1:0]                          status;
  logic [terd_pkg::OUT_DATA_W-1:0]     data_d;

  assign q_pop_o = q_valid_i && (!valid_q || m_axis_tready);

  // field decode, zero where the field does not belong to the kind
  always_comb begin
    block_nr = '0;
    lon      = '0;
    lat      = '0;
    idx      = '0;
    height   = '0;
    status   = '0;
    mag      = {1'b0, q_token_i.payload[14:0]};
    unique case (q_token_i.kind)
      terd_pkg::KIND_HEADER: begin
        block_nr = q_token_i.payload[55:32];
        lon      = q_token_i.payload[31:16];
        lat      = q_token_i.payload[15:0];
      end
      terd_pkg::KIND_ELEV: begin
        idx    = q_token_i.payload[27:16];
        height = q_token_i.payload[15] ? -$signed(mag) : $signed(mag);
      end
      terd_pkg::KIND_STATUS: begin
        status = q_token_i.payload[1:0];
      end
      default: begin
      end
    endcase
    data_d = {2'b00, status, height, idx, lat, lon, block_nr};
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      kind_q <= q_token_i.kind;
      data_q <= data_d;
      last_q <= (q_token_i.kind == terd_pkg::KIND_STATUS);
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;

  a_last_on_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (kind_q == terd_pkg::KIND_STATUS)))
    else $error("tlast does not match a status beat");

endmodule

@@ sv/terrain_record_deframer.sv @@
// top level of the terrain record deframer
// The block takes one record byte per cycle on the slave stream. If the first byte is the
// sentinel, it emits a header beat (tuser 0) after the eighth byte and an elevation beat
// (tuser 1) after the second byte of each point; a status beat (tuser 2, tlast high)
// follows the fourth checksum byte. A byte is classified and the running byte sum updated
// in the cycle it is taken; its result enters a four-entry queue at the edge that takes
// the byte and reaches the output register in queue order once that register is free, so
// the sustained rate is one byte per cycle and input stalls only when that queue is full.
// The point count register is written on the cfg channel, which is always ready, and
// should only change between records; zero acts as one and values above MAX_POINTS
// are clamped.
module terrain_record_deframer #(
  parameter int unsigned MAX_POINTS = 3601
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write channel: points_per_record
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [terd_pkg::PTS_W-1:0]       cfg_data_i,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // [7:0] in_byte
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [23:0] block_number, [39:24] lon_line, [55:40] lat_line, [67:56] point_index,
  // [83:68] height, [85:84] status, [87:86] zero
  output logic [terd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic [1:0]                       m_axis_tuser,   // [1:0] kind
  output logic                             m_axis_tlast    // last
);

  logic [terd_pkg::PTS_W-1:0] pts_q;
  logic                       push, full, pop, q_valid;
  terd_pkg::token_t           push_token, pop_token;

  assign cfg_ready_o = 1'b1;

  // point count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_q <= terd_pkg::PTS_RESET;
    end else if (cfg_valid_i) begin
      pts_q <= cfg_data_i;
    end
  end

  terd_front #(
    .MaxPoints (MAX_POINTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .points_i   (pts_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .full_i     (full),
    .push_o     (push),
    .token_o    (push_token)
  );

  terd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .token_i (push_token),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .token_o (pop_token)
  );

  terd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_token_i     (pop_token),
    .q_pop_o       (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
